// ----- rtl/core/hspd_pkg.sv -----
// Shared types, codes and frame decode function for the humidity sensor pulse decoder.
package hspd_pkg;

    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int FRAME_W     = 40;
    localparam int COUNT_W     = 6;
    localparam int WIDTH_W     = 16;
    localparam logic [COUNT_W-1:0] LAST_PULSE = COUNT_W'(FRAME_W);
    localparam logic [7:0]         MS_SAT     = 8'hFF;

    typedef enum logic [1:0] {
        FUNC_ARM   = 2'd0,
        FUNC_PULSE = 2'd1,
        FUNC_TICK  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_CHECKSUM = 2'd2,
        ST_TIMEOUT  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SENS_T11 = 2'd0,
        SENS_T12 = 2'd1,
        SENS_T21 = 2'd2,
        SENS_T22 = 2'd3
    } sensor_t;

    typedef enum logic [1:0] {
        REG_SENSOR_TYPE = 2'd0,
        REG_BIT_THRESH  = 2'd1,
        REG_START_MIN   = 2'd2,
        REG_TIMEOUT     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        status_t            status;
        logic signed [15:0] temp;
        logic [15:0]        hum;
        logic [FRAME_W-1:0] frame;
    } result_t;

    function automatic result_t decode_frame(
        input logic [1:0]         stype,
        input logic               start_ok,
        input logic [FRAME_W-1:0] frame
    );
        logic [7:0]         b0;
        logic [7:0]         b1;
        logic [7:0]         b2;
        logic [7:0]         b3;
        logic [7:0]         b4;
        logic [7:0]         sum;
        logic [15:0]        tmag;
        logic signed [15:0] temp;
        logic [15:0]        hum;
        result_t            r;
        b0   = frame[39:32];
        b1   = frame[31:24];
        b2   = frame[23:16];
        b3   = frame[15:8];
        b4   = frame[7:0];
        sum  = b0 + b1 + b2 + b3;
        tmag = 16'd0;
        temp = 16'sd0;
        hum  = 16'd0;
        r.status = ST_OK;
        r.frame  = frame;
        case (stype)
            SENS_T11:
            begin
                hum  = {8'd0, b0} * 16'd10 + {8'd0, b1};
                tmag = {8'd0, b2} * 16'd10;
                if (b3[7])
                begin
                    temp = -16'sd10 - $signed(tmag);
                end
                else
                begin
                    temp = $signed(tmag);
                end
                temp = temp + $signed({12'd0, b3[3:0]});
            end
            SENS_T12:
            begin
                hum  = {8'd0, b0} * 16'd10 + {8'd0, b1};
                tmag = {8'd0, b2} * 16'd10 + {12'd0, b3[3:0]};
                temp = b2[7] ? -$signed(tmag) : $signed(tmag);
            end
            default:
            begin
                hum  = {b0, b1};
                tmag = {1'b0, b2[6:0], b3};
                temp = b2[7] ? -$signed(tmag) : $signed(tmag);
            end
        endcase
        if (!start_ok)
        begin
            r.status = ST_SHORT;
            r.temp   = 16'sd0;
            r.hum    = 16'd0;
        end
        else if (sum != b4)
        begin
            r.status = ST_CHECKSUM;
            r.temp   = 16'sd0;
            r.hum    = 16'd0;
        end
        else
        begin
            r.temp = temp;
            r.hum  = hum;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/humidity_sensor_pulse_decoder_core.sv -----
// Top level of the humidity sensor pulse decoder: input register, decode step, result register.
//
//  Channel   Handshake           Payload
//  ------    ------------------  ------------------------------------------------
//  input     in_valid/in_stall   func, pulse_width_us
//  output    out_valid/out_stall status, temperature_tenths, humidity_tenths,
//                                raw_frame
//  config    APB write/read      sensor_type, bit_threshold_us, start_min_us,
//                                timeout_ms at byte addresses 0, 4, 8, 12
//
//  One transfer per cycle in while in_stall is low.
//  The decode step (shift, checksum, per-type formula) sits between the input
//  register and the result register. Reset clears all control state and
//  loads the register defaults. A held result only stalls an item that itself
//  yields a result; other items pass through and update state.
module humidity_sensor_pulse_decoder_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  func,
    input  logic [15:0]                 pulse_width_us,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic signed [15:0]          temperature_tenths,
    output logic [15:0]                 humidity_tenths,
    output logic [39:0]                 raw_frame,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hspd_pkg::ADDR_W-1:0] paddr,
    input  logic [hspd_pkg::DATA_W-1:0] pwdata,
    output logic [hspd_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import hspd_pkg::*;

    logic [1:0]         sensor_type_reg;
    logic [7:0]         bit_thresh_reg;
    logic [7:0]         start_min_reg;
    logic [7:0]         timeout_reg;

    logic               s1_valid_reg;
    logic [1:0]         s1_func_reg;
    logic [WIDTH_W-1:0] s1_width_reg;

    logic               armed_reg;
    logic               armed_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               start_ok_reg;
    logic               start_ok_next;
    logic [FRAME_W-1:0] shift_reg;
    logic [FRAME_W-1:0] shift_next;
    logic [7:0]         elapsed_reg;
    logic [7:0]         elapsed_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            out_reg;
    result_t            res_next;

    logic               has_result;
    logic               out_free;
    logic               s1_fire;
    logic               in_accept;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_type_reg <= SENS_T22;
            bit_thresh_reg  <= 8'd40;
            start_min_reg   <= 8'd40;
            timeout_reg     <= 8'd20;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_SENSOR_TYPE: sensor_type_reg <= pwdata[1:0];
                REG_BIT_THRESH:  bit_thresh_reg  <= pwdata[7:0];
                REG_START_MIN:   start_min_reg   <= pwdata[7:0];
                REG_TIMEOUT:     timeout_reg     <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SENSOR_TYPE: prdata = {30'd0, sensor_type_reg};
            REG_BIT_THRESH:  prdata = {24'd0, bit_thresh_reg};
            REG_START_MIN:   prdata = {24'd0, start_min_reg};
            REG_TIMEOUT:     prdata = {24'd0, timeout_reg};
            default:         prdata = '0;
        endcase
    end

    // decode step: next state and result of the item in the input register
    always_comb
    begin
        armed_next    = armed_reg;
        count_next    = count_reg;
        start_ok_next = start_ok_reg;
        shift_next    = shift_reg;
        elapsed_next  = elapsed_reg;
        has_result    = 1'b0;
        res_next      = '{status: ST_TIMEOUT, temp: 16'sd0, hum: 16'd0, frame: '0};
        case (s1_func_reg)
            FUNC_ARM:
            begin
                armed_next    = 1'b1;
                count_next    = '0;
                start_ok_next = 1'b0;
                shift_next    = '0;
                elapsed_next  = 8'd0;
            end
            FUNC_PULSE:
            begin
                if (armed_reg)
                begin
                    if (count_reg == '0)
                    begin
                        start_ok_next = s1_width_reg >= {8'd0, start_min_reg};
                    end
                    else
                    begin
                        shift_next = {shift_reg[FRAME_W-2:0],
                                      s1_width_reg > {8'd0, bit_thresh_reg}};
                    end
                    count_next = count_reg + 1'b1;
                    if (count_reg == LAST_PULSE)
                    begin
                        armed_next = 1'b0;
                        count_next = '0;
                        has_result = 1'b1;
                        res_next   = decode_frame(sensor_type_reg, start_ok_next, shift_next);
                    end
                end
            end
            FUNC_TICK:
            begin
                if (armed_reg)
                begin
                    if (elapsed_reg != MS_SAT)
                    begin
                        elapsed_next = elapsed_reg + 8'd1;
                    end
                    if (elapsed_next >= timeout_reg)
                    begin
                        armed_next = 1'b0;
                        count_next = '0;
                        has_result = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign out_free       = !out_valid_reg || !out_stall;
    assign s1_fire        = s1_valid_reg && (!has_result || out_free);
    assign in_stall       = s1_valid_reg && !s1_fire;
    assign in_accept      = in_valid && !in_stall;
    assign out_valid_next = (s1_fire && has_result) || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            armed_reg     <= 1'b0;
            count_reg     <= '0;
            start_ok_reg  <= 1'b0;
            shift_reg     <= '0;
            elapsed_reg   <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_accept || (s1_valid_reg && !s1_fire);
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                armed_reg    <= armed_next;
                count_reg    <= count_next;
                start_ok_reg <= start_ok_next;
                shift_reg    <= shift_next;
                elapsed_reg  <= elapsed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg  <= func;
            s1_width_reg <= pulse_width_us;
        end
        if (s1_fire && has_result)
        begin
            out_reg <= res_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = out_reg.status;
    assign temperature_tenths = out_reg.temp;
    assign humidity_tenths    = out_reg.hum;
    assign raw_frame          = out_reg.frame;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LAST_PULSE)
        else $error("pulse count beyond frame length");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> count_reg == '0)
        else $error("pulse count non-zero while not armed");

    a_timeout_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == ST_TIMEOUT |-> out_reg.frame == '0)
        else $error("timeout result carries frame bits");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_fire && has_result))
        else $error("result register loaded without a decoded item");

endmodule

// ----- test/tb_top.sv -----
// Testbench for humidity_sensor_pulse_decoder_core: random sensor frames checked against a decode model.
module tb_top;
    import hspd_pkg::*;

    localparam logic [1:0]  FUNC_UNUSED = 2'd3;
    localparam int          NUM_PHASES  = 10;
    localparam int          PHASE_ITEMS = 125;
    localparam int          MAX_SHOWN   = 10;
    localparam int unsigned CYCLE_LIMIT = 600000;

    class reading_scoreboard;
        sensor_t     sensor;
        logic [7:0]  bit_thr;
        logic [7:0]  start_min;
        logic [7:0]  tmo;
        bit          armed;
        int unsigned pulses;
        bit          start_good;
        logic [39:0] shift_reg;
        logic [7:0]  ms;
        result_t     pending_readings[$];
        int unsigned consumed;
        int unsigned mismatches;
        int unsigned status_count[4];

        function new();
            sensor     = SENS_T22;
            bit_thr    = 8'd40;
            start_min  = 8'd40;
            tmo        = 8'd20;
            armed      = 1'b0;
            pulses     = 0;
            start_good = 1'b0;
            shift_reg  = '0;
            ms         = '0;
            consumed   = 0;
            mismatches = 0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [7:0] v);
            case (idx)
                REG_SENSOR_TYPE: sensor = sensor_t'(v[1:0]);
                REG_BIT_THRESH:  bit_thr = v;
                REG_START_MIN:   start_min = v;
                default:         tmo = v;
            endcase
        endfunction

        function logic [31:0] reg_value(reg_idx_t idx);
            case (idx)
                REG_SENSOR_TYPE: return {30'd0, sensor};
                REG_BIT_THRESH:  return {24'd0, bit_thr};
                REG_START_MIN:   return {24'd0, start_min};
                default:         return {24'd0, tmo};
            endcase
        endfunction

        function void report(string what, logic [63:0] exp_v, logic [63:0] act_v);
            mismatches++;
            if (mismatches <= MAX_SHOWN)
            begin
                $display("mismatch in %s: expected %h, got %h", what, exp_v, act_v);
            end
        endfunction

        function result_t decode_reading();
            logic [7:0] b0;
            logic [7:0] b1;
            logic [7:0] b2;
            logic [7:0] b3;
            logic [7:0] b4;
            logic [7:0] sum;
            int         t;
            int         h;
            result_t    r;
            {b0, b1, b2, b3, b4} = shift_reg;
            sum = b0 + b1 + b2 + b3;
            r.frame = shift_reg;
            r.temp = '0;
            r.hum = '0;
            if (!start_good)
            begin
                r.status = ST_SHORT;
            end
            else if (sum != b4)
            begin
                r.status = ST_CHECKSUM;
            end
            else
            begin
                r.status = ST_OK;
                case (sensor)
                    SENS_T11:
                    begin
                        h = int'(b0) * 10 + int'(b1);
                        t = int'(b2) * 10;
                        if (b3[7]) t = -10 - t;
                        t = t + int'(b3[3:0]);
                    end
                    SENS_T12:
                    begin
                        h = int'(b0) * 10 + int'(b1);
                        t = int'(b2) * 10 + int'(b3[3:0]);
                        if (b2[7]) t = -t;
                    end
                    default:
                    begin
                        h = int'({b0, b1});
                        t = int'({b2[6:0], b3});
                        if (b2[7]) t = -t;
                    end
                endcase
                r.temp = 16'(t);
                r.hum = 16'(h);
            end
            return r;
        endfunction

        function void push_reading(result_t r);
            pending_readings.push_back(r);
            status_count[r.status]++;
        endfunction

        function void note_input(logic [1:0] f, logic [15:0] w);
            result_t r;
            if (f == FUNC_ARM)
            begin
                armed = 1'b1;
                pulses = 0;
                start_good = 1'b0;
                shift_reg = '0;
                ms = '0;
                consumed++;
                return;
            end
            if (!armed || f == FUNC_UNUSED) return;
            consumed++;
            if (f == FUNC_PULSE)
            begin
                if (pulses == 0) start_good = (w >= start_min);
                else shift_reg = {shift_reg[38:0], w > bit_thr};
                pulses++;
                if (pulses >= 41)
                begin
                    armed = 1'b0;
                    pulses = 0;
                    push_reading(decode_reading());
                end
            end
            else
            begin
                if (ms < 8'hFF) ms++;
                if (ms >= tmo)
                begin
                    armed = 1'b0;
                    pulses = 0;
                    r.status = ST_TIMEOUT;
                    r.temp = '0;
                    r.hum = '0;
                    r.frame = '0;
                    push_reading(r);
                end
            end
        endfunction

        function void check_result(logic [1:0] st, logic signed [15:0] tp, logic [15:0] hm,
                                   logic [39:0] fr);
            result_t e;
            if (pending_readings.size() == 0)
            begin
                report("unexpected result status", 64'hx, 64'(st));
                return;
            end
            e = pending_readings.pop_front();
            if (e.status !== st) report("status", 64'(e.status), 64'(st));
            if (e.temp !== tp) report("temperature_tenths", 64'(e.temp), 64'(tp));
            if (e.hum !== hm) report("humidity_tenths", 64'(e.hum), 64'(hm));
            if (e.frame !== fr) report("raw_frame", 64'(e.frame), 64'(fr));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [1:0]           func = '0;
    logic [15:0]          pulse_width_us = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           status;
    logic signed [15:0]   temperature_tenths;
    logic [15:0]          humidity_tenths;
    logic [39:0]          raw_frame;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    reading_scoreboard board = new();
    int unsigned       cycles = 0;
    int unsigned       stall_run = 0;
    int unsigned       gap_quiet_left = 0;

    sensor_t    ph_sensor [NUM_PHASES] = '{SENS_T22, SENS_T12, SENS_T11, SENS_T21, SENS_T11,
                                           SENS_T12, SENS_T22, SENS_T21, SENS_T11, SENS_T12};
    logic [7:0] ph_thr    [NUM_PHASES] = '{8'd40, 8'd1, 8'd40, 8'd255, 8'd0,
                                           8'd100, 8'd128, 8'd60, 8'd12, 8'd254};
    logic [7:0] ph_smin   [NUM_PHASES] = '{8'd40, 8'd1, 8'd80, 8'd255, 8'd0,
                                           8'd30, 8'd200, 8'd10, 8'd255, 8'd128};
    logic [7:0] ph_tmo    [NUM_PHASES] = '{8'd20, 8'd1, 8'd20, 8'd255, 8'd0,
                                           8'd50, 8'd5, 8'd100, 8'd3, 8'd200};

    humidity_sensor_pulse_decoder_core dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .func               (func),
        .pulse_width_us     (pulse_width_us),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .status             (status),
        .temperature_tenths (temperature_tenths),
        .humidity_tenths    (humidity_tenths),
        .raw_frame          (raw_frame),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("humidity_sensor_pulse_decoder_core test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            board.check_result(status, temperature_tenths, humidity_tenths, raw_frame);
        end
    end

    always @(posedge clk)
    begin : stall_gen
        int unsigned pick;
        if (stall_run != 0)
        begin
            stall_run <= stall_run - 1;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                out_stall <= 1'b0;
                stall_run <= $urandom_range(100, 300);
            end
            else if (pick < 50)
            begin
                out_stall <= 1'b0;
                stall_run <= $urandom_range(0, 6);
            end
            else if (pick < 88)
            begin
                out_stall <= 1'b1;
                stall_run <= $urandom_range(0, 3);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_run <= $urandom_range(10, 40);
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned pick;
        if (gap_quiet_left != 0)
        begin
            gap_quiet_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 2) gap_quiet_left = $urandom_range(40, 150);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic send_item(logic [1:0] f, logic [15:0] w);
        int unsigned gap;
        in_valid <= 1'b1;
        func <= f;
        pulse_width_us <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_input(f, w);
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic apb_write(reg_idx_t idx, logic [7:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        board.set_reg(idx, v);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(reg_idx_t idx, output logic [31:0] d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        d = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_regs();
        logic [31:0] rd;
        reg_idx_t    idx;
        for (int i = 0; i < 4; i++)
        begin
            idx = reg_idx_t'(i);
            apb_read(idx, rd);
            if (rd !== board.reg_value(idx)) board.report("register readback",
                                                          64'(board.reg_value(idx)), 64'(rd));
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_readings.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_byte();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] bit_width(logic one);
        int unsigned thr;
        thr = board.bit_thr;
        if (one)
        begin
            if ($urandom_range(0, 1) == 0) return 16'($urandom_range(thr + 1, thr + 16));
            return 16'($urandom_range(thr + 1, 65535));
        end
        if ($urandom_range(0, 1) == 0) return 16'($urandom_range(thr > 15 ? thr - 15 : 0, thr));
        return 16'($urandom_range(0, thr));
    endfunction

    function automatic logic [15:0] start_width(bit good);
        int unsigned smin;
        smin = board.start_min;
        if (!good && smin != 0) return 16'($urandom_range(0, smin - 1));
        if ($urandom_range(0, 1) == 0) return 16'($urandom_range(smin, smin + 20));
        return 16'($urandom_range(smin, 65535));
    endfunction

    task automatic run_frame();
        int unsigned mode;
        int unsigned lead;
        int unsigned ticks_left;
        int unsigned guard;
        logic [7:0]  b [5];
        logic [39:0] data;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 4; i++) b[i] = rand_byte();
        b[4] = b[0] + b[1] + b[2] + b[3];
        if (mode == 5) b[4] = b[4] ^ 8'($urandom_range(1, 255));
        data = {b[0], b[1], b[2], b[3], b[4]};
        ticks_left = (board.tmo > 1) ? $urandom_range(0, board.tmo - 1) : 0;
        send_item(FUNC_ARM, 16'($urandom()));
        if (mode == 7 || mode == 8 || mode == 9)
        begin
            lead = $urandom_range(1, 40);
            for (int i = 0; i < lead; i++) send_item(FUNC_PULSE, 16'($urandom()));
            if (mode == 9) return;
            if (mode == 7)
            begin
                guard = 0;
                while (board.armed && guard < 300)
                begin
                    send_item(FUNC_TICK, 16'($urandom()));
                    guard++;
                end
                return;
            end
            send_item(FUNC_ARM, 16'($urandom()));
        end
        send_item(FUNC_PULSE, start_width(mode != 6));
        for (int i = 39; i >= 0; i--)
        begin
            if (ticks_left != 0 && $urandom_range(0, 9) == 0)
            begin
                send_item(FUNC_TICK, 16'($urandom()));
                ticks_left--;
            end
            send_item(FUNC_PULSE, bit_width(data[i]));
        end
    endtask

    initial
    begin
        int unsigned target;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p != 0)
            begin
                drain();
                apb_write(REG_SENSOR_TYPE, {6'd0, ph_sensor[p]});
                apb_write(REG_BIT_THRESH, ph_thr[p]);
                apb_write(REG_START_MIN, ph_smin[p]);
                apb_write(REG_TIMEOUT, ph_tmo[p]);
            end
            check_regs();
            if (p == 1)
            begin
                send_item(FUNC_PULSE, 16'hFFFF);
                send_item(FUNC_TICK, 16'h0000);
                send_item(FUNC_UNUSED, 16'hFFFF);
                send_item(FUNC_ARM, 16'h0000);
                send_item(FUNC_UNUSED, 16'h0000);
                send_item(FUNC_PULSE, 16'h0000);
                send_item(FUNC_PULSE, 16'hFFFF);
                send_item(FUNC_PULSE, 16'h0001);
                send_item(FUNC_ARM, 16'hFFFF);
                send_item(FUNC_PULSE, 16'h0001);
                send_item(FUNC_TICK, 16'hFFFF);
                send_item(FUNC_TICK, 16'h0000);
                send_item(FUNC_PULSE, 16'h0002);
            end
            if (p == 4)
            begin
                send_item(FUNC_ARM, 16'h5555);
                send_item(FUNC_TICK, 16'hAAAA);
            end
            target = board.consumed + PHASE_ITEMS;
            while (board.consumed < target)
            begin
                if ($urandom_range(0, 99) < 10)
                begin
                    send_item(2'($urandom_range(0, 3)), 16'($urandom()));
                end
                else
                begin
                    run_frame();
                end
            end
        end
        drain();
        $display("Covered %0d accepted items over %0d register settings in %0d cycles",
                 board.consumed, NUM_PHASES, cycles);
        $display("Readings: %0d ok, %0d short response, %0d bad checksum, %0d timeout",
                 board.status_count[ST_OK], board.status_count[ST_SHORT],
                 board.status_count[ST_CHECKSUM], board.status_count[ST_TIMEOUT]);
        if (board.mismatches == 0 && board.pending_readings.size() == 0)
        begin
            $display("humidity_sensor_pulse_decoder_core test passed");
        end
        else
        begin
            $display("humidity_sensor_pulse_decoder_core test failed");
        end
        $finish;
    end
endmodule
